// File: rtl/greedy_voxel_face_mesher_assert.svh
// Assertion macros for the greedy voxel face mesher.
`ifndef GREEDY_VOXEL_FACE_MESHER_ASSERT_SVH
`define GREEDY_VOXEL_FACE_MESHER_ASSERT_SVH

// Condition holds at every edge outside reset.
`define GVFM_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("gvfm assertion failed");

// Antecedent implies consequent in the same cycle.
`define GVFM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gvfm assertion failed");

`endif

// File: rtl/gvfm_pkg.sv
// Package: constants, codes and types of the greedy voxel face mesher.
`default_nettype none
package gvfm_pkg;
   localparam int CHUNK_SIZE  = 32;
   localparam int SIDE        = CHUNK_SIZE + 2;
   localparam int VOL_CELLS   = SIDE * SIDE * SIDE;
   localparam int PLANE_CELLS = CHUNK_SIZE * CHUNK_SIZE;
   localparam int VOX_AW      = $clog2(VOL_CELLS);
   localparam int MASK_AW     = $clog2(PLANE_CELLS);
   localparam int CW          = $clog2(CHUNK_SIZE);
   localparam int CNT_W       = CW + 1;
   localparam int COORD_W     = 6;
   localparam int BLOCK_W     = 16;
   localparam int VOX_W       = 18;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;

   localparam logic       REQ_LOAD           = 1'b0;
   localparam logic       REQ_QUAD           = 1'b1;
   localparam logic       CSR_MERGE_ENABLE   = 1'b0;
   localparam logic       CSR_MERGE_BY_BLOCK = 1'b1;
   localparam logic [1:0] SIGN_NONE          = 2'd0;
   localparam logic [1:0] SIGN_PLUS          = 2'd1;
   localparam logic [1:0] SIGN_MINUS         = 2'd2;
   localparam logic [1:0] AXIS_X             = 2'd0;
   localparam logic [1:0] AXIS_Y             = 2'd1;
   localparam logic [1:0] AXIS_Z             = 2'd2;

   typedef enum logic [1:0] {PH_IDLE, PH_SCAN, PH_DONE} phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BLD_NEG, ST_BLD_POS, ST_BLD_WR, ST_FIND_RD, ST_FIND_CHK,
      ST_W_RD, ST_W_CHK, ST_H_RD, ST_H_CHK, ST_CLR, ST_NEXT_PLANE
   } state_type;
endpackage
`default_nettype wire

// File: rtl/gvfm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gvfm_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/greedy_voxel_face_mesher.sv
// Top level: voxel store, face mask memory and the greedy meshing sequencer.
//
//  channel | ports                        | payload
//  --------+------------------------------+--------------------------------------
//  request | req_tvalid/tready/tdata/tuser| tuser: req_type; tdata: voxel fields
//  result  | rsp_tvalid/tready/tdata/tuser| tuser: mesh_done; tdata: quad fields
//  control | csr_we/index/wdata           | merge_enable, merge_by_block
//
// A load is written in the cycle it is accepted. A quad request walks the
// mask: each cell of a plane is rebuilt from two voxel-store reads and one
// mask write; cells are then scanned, probed to widen and grow, and cleared.
// Reset is synchronous; the voxel store holds no reset value and the mask is
// rebuilt before each plane is read, so neither needs a clearing pass.
// A quad request waits while the result register holds a quad not taken in
// that cycle; loads never wait on the result side.
`default_nettype none
module greedy_voxel_face_mesher (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // x[5:0], y[11:6], z[17:12], block[33:18], solid[34], occludes[35], zero pad
   input  wire logic [gvfm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[0]
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // axis[1:0], positive[2], slice[8:3], u[13:9], v[18:14], width[24:19],
   // height[30:25], block[46:31], zero pad
   output logic      [gvfm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // mesh_done[0]
   output logic                                   rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic                              csr_wdata
);
   import gvfm_pkg::*;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [1:0]           axis_ff, axis_in;
   logic [CNT_W-1:0]     slice_ff, slice_in, row_ff, row_in, col_ff, col_in;
   logic [CW-1:0]        bi_ff, bi_in, bj_ff, bj_in;
   logic [VOX_W-1:0]     cell_ff, cell_in, neg_ff, neg_in;
   logic [CNT_W-1:0]     w_ff, w_in, h_ff, h_in, hw_ff, hw_in, cr_ff, cr_in;
   logic                 merge_en_ff, merge_blk_ff;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_done_ff, rsp_done_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 vox_we;
   logic [VOX_AW-1:0]    vox_waddr, vox_raddr;
   logic [VOX_W-1:0]     vox_wdata, vox_rdata;
   logic                 mask_we;
   logic [MASK_AW-1:0]   mask_waddr, mask_raddr;
   logic [VOX_W-1:0]     mask_wdata, mask_rdata;

   logic                 req_accept;
   logic [COORD_W-1:0]   ld_x, ld_y, ld_z, pi, pj, ps, ps1;
   logic [COORD_W-1:0]   nx, ny, nz, px, py, pz;
   logic [VOX_W-1:0]     pos_vox, new_cell;
   logic [CNT_W:0]       col_w, row_h;

   function automatic logic [VOX_AW-1:0] vaddr(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [COORD_W-1:0] z);
      vaddr = VOX_AW'(int'(x) + SIDE * (int'(y) + SIDE * int'(z)));
   endfunction

   function automatic logic [MASK_AW-1:0] maddr(input logic [CNT_W:0] r,
                                                input logic [CNT_W:0] c);
      maddr = MASK_AW'(int'(r) * CHUNK_SIZE + int'(c));
   endfunction

   function automatic logic same_face(input logic [VOX_W-1:0] a,
                                      input logic [VOX_W-1:0] c,
                                      input logic             by_block);
      same_face = (a[17:16] != SIGN_NONE) && (a[17:16] == c[17:16]) &&
                  (!by_block || (a[15:0] == c[15:0]));
   endfunction

   gvfm_ram #(.WIDTH(VOX_W), .DEPTH(VOL_CELLS)) u_voxel_ram (
      .clock(clock), .we(vox_we), .waddr(vox_waddr), .wdata(vox_wdata),
      .raddr(vox_raddr), .rdata(vox_rdata)
   );

   gvfm_ram #(.WIDTH(VOX_W), .DEPTH(PLANE_CELLS)) u_mask_ram (
      .clock(clock), .we(mask_we), .waddr(mask_waddr), .wdata(mask_wdata),
      .raddr(mask_raddr), .rdata(mask_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE) &&
                       ((req_tuser == REQ_LOAD) || !rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   assign ld_x = req_tdata[5:0];
   assign ld_y = req_tdata[11:6];
   assign ld_z = req_tdata[17:12];

   // plane neighbor coordinates for the mask build
   assign pi  = COORD_W'(bi_ff) + COORD_W'(1);
   assign pj  = COORD_W'(bj_ff) + COORD_W'(1);
   assign ps  = COORD_W'(slice_ff);
   assign ps1 = COORD_W'(slice_ff) + COORD_W'(1);

   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            nx = ps;  ny = pi;  nz = pj;
            px = ps1; py = pi;  pz = pj;
         end
         AXIS_Y: begin
            nx = pj;  ny = ps;  nz = pi;
            px = pj;  py = ps1; pz = pi;
         end
         default: begin
            nx = pi;  ny = pj;  nz = ps;
            px = pi;  py = pj;  pz = ps1;
         end
      endcase
   end

   assign pos_vox = vox_rdata;
   always_comb begin
      new_cell = '0;
      if (neg_ff[16] && !pos_vox[17]) begin
         new_cell = {SIGN_PLUS, neg_ff[15:0]};
      end else if (pos_vox[16] && !neg_ff[17]) begin
         new_cell = {SIGN_MINUS, pos_vox[15:0]};
      end
   end

   assign col_w = {1'b0, col_ff} + {1'b0, w_ff};
   assign row_h = {1'b0, row_ff} + {1'b0, h_ff};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      axis_in      = axis_ff;
      slice_in     = slice_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      bi_in        = bi_ff;
      bj_in        = bj_ff;
      cell_in      = cell_ff;
      neg_in       = neg_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      hw_in        = hw_ff;
      cr_in        = cr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_done_in  = rsp_done_ff;
      rsp_data_in  = rsp_data_ff;
      vox_we       = 1'b0;
      vox_waddr    = vaddr(ld_x, ld_y, ld_z);
      vox_wdata    = {req_tdata[35], req_tdata[34], req_tdata[33:18]};
      vox_raddr    = vaddr(nx, ny, nz);
      mask_we      = 1'b0;
      mask_waddr   = maddr({2'b0, bj_ff}, {2'b0, bi_ff});
      mask_wdata   = new_cell;
      mask_raddr   = maddr({1'b0, row_ff}, {1'b0, col_ff});

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == REQ_LOAD) begin
                  vox_we   = (int'(ld_x) < SIDE) && (int'(ld_y) < SIDE) &&
                             (int'(ld_z) < SIDE);
                  phase_in = PH_IDLE;
               end else begin
                  unique case (phase_ff)
                     PH_DONE: begin
                        rsp_valid_in = 1'b1;
                        rsp_done_in  = 1'b1;
                        rsp_data_in  = '0;
                     end
                     PH_IDLE: begin
                        axis_in  = AXIS_X;
                        slice_in = '0;
                        row_in   = '0;
                        col_in   = '0;
                        bi_in    = '0;
                        bj_in    = '0;
                        phase_in = PH_SCAN;
                        state_in = ST_BLD_NEG;
                     end
                     default: begin
                        state_in = ST_FIND_RD;
                     end
                  endcase
               end
            end
         end
         ST_BLD_NEG: begin
            state_in = ST_BLD_POS;
         end
         ST_BLD_POS: begin
            vox_raddr = vaddr(px, py, pz);
            neg_in    = vox_rdata;
            state_in  = ST_BLD_WR;
         end
         ST_BLD_WR: begin
            mask_we  = 1'b1;
            state_in = ST_BLD_NEG;
            if (int'(bi_ff) == CHUNK_SIZE - 1) begin
               bi_in = '0;
               if (int'(bj_ff) == CHUNK_SIZE - 1) begin
                  bj_in    = '0;
                  state_in = ST_FIND_RD;
               end else begin
                  bj_in = bj_ff + CW'(1);
               end
            end else begin
               bi_in = bi_ff + CW'(1);
            end
         end
         ST_FIND_RD: begin
            if (int'(col_ff) >= CHUNK_SIZE) begin
               col_in = '0;
               if (int'(row_ff) == CHUNK_SIZE - 1) begin
                  state_in = ST_NEXT_PLANE;
               end else begin
                  row_in = row_ff + CNT_W'(1);
               end
            end else begin
               state_in = ST_FIND_CHK;
            end
         end
         ST_NEXT_PLANE: begin
            row_in   = '0;
            col_in   = '0;
            state_in = ST_BLD_NEG;
            if (int'(slice_ff) == CHUNK_SIZE) begin
               slice_in = '0;
               if (axis_ff == AXIS_Z) begin
                  axis_in      = AXIS_X;
                  phase_in     = PH_DONE;
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_done_in  = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               slice_in = slice_ff + CNT_W'(1);
            end
         end
         ST_FIND_CHK: begin
            if (mask_rdata[17:16] == SIGN_NONE) begin
               col_in   = col_ff + CNT_W'(1);
               state_in = ST_FIND_RD;
            end else begin
               cell_in = mask_rdata;
               w_in    = CNT_W'(1);
               h_in    = CNT_W'(1);
               hw_in   = '0;
               cr_in   = '0;
               if (!merge_en_ff) begin
                  state_in = ST_CLR;
               end else if (int'(col_ff) + 1 < CHUNK_SIZE) begin
                  state_in = ST_W_RD;
               end else begin
                  state_in = ST_H_RD;
               end
            end
         end
         ST_W_RD: begin
            mask_raddr = maddr({1'b0, row_ff}, col_w);
            state_in   = ST_W_CHK;
         end
         ST_W_CHK: begin
            hw_in    = '0;
            state_in = ST_H_RD;
            if (same_face(mask_rdata, cell_ff, merge_blk_ff)) begin
               w_in = w_ff + CNT_W'(1);
               if (int'(col_w) + 1 < CHUNK_SIZE) begin
                  state_in = ST_W_RD;
               end
            end
         end
         ST_H_RD: begin
            mask_raddr = maddr(row_h, {1'b0, col_ff} + {1'b0, hw_ff});
            if (int'(row_h) >= CHUNK_SIZE) begin
               hw_in    = '0;
               cr_in    = '0;
               state_in = ST_CLR;
            end else begin
               state_in = ST_H_CHK;
            end
         end
         ST_H_CHK: begin
            state_in = ST_H_RD;
            if (!same_face(mask_rdata, cell_ff, merge_blk_ff)) begin
               hw_in    = '0;
               cr_in    = '0;
               state_in = ST_CLR;
            end else if (hw_ff + CNT_W'(1) == w_ff) begin
               hw_in = '0;
               h_in  = h_ff + CNT_W'(1);
            end else begin
               hw_in = hw_ff + CNT_W'(1);
            end
         end
         ST_CLR: begin
            mask_we    = 1'b1;
            mask_wdata = '0;
            mask_waddr = maddr({1'b0, row_ff} + {1'b0, cr_ff},
                               {1'b0, col_ff} + {1'b0, hw_ff});
            if (hw_ff + CNT_W'(1) == w_ff) begin
               hw_in = '0;
               if (cr_ff + CNT_W'(1) == h_ff) begin
                  col_in       = CNT_W'(col_w);
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_done_in  = 1'b0;
                  rsp_data_in  = {1'b0, cell_ff[15:0], 6'(h_ff), 6'(w_ff),
                                  5'(row_ff), 5'(col_ff), 6'(slice_ff),
                                  cell_ff[17:16] == SIGN_PLUS, axis_ff};
               end else begin
                  cr_in = cr_ff + CNT_W'(1);
               end
            end else begin
               hw_in = hw_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         axis_ff      <= AXIS_X;
         slice_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         bi_ff        <= '0;
         bj_ff        <= '0;
         merge_en_ff  <= 1'b1;
         merge_blk_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         axis_ff      <= axis_in;
         slice_ff     <= slice_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         bi_ff        <= bi_in;
         bj_ff        <= bj_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MERGE_ENABLE:   merge_en_ff  <= csr_wdata;
               CSR_MERGE_BY_BLOCK: merge_blk_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      neg_ff      <= neg_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      hw_ff       <= hw_in;
      cr_ff       <= cr_in;
      rsp_done_ff <= rsp_done_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "greedy_voxel_face_mesher_assert.svh"
   `GVFM_ASSERT_SAME(a_busy_blocks_req, state_ff != ST_IDLE, !req_tready)
   `GVFM_ASSERT_SAME(a_quad_slot_free, req_accept && req_tuser == REQ_QUAD,
                     !rsp_valid_ff || rsp_tready)
   `GVFM_ASSERT_SAME(a_quad_nonempty, rsp_valid_ff && !rsp_done_ff,
                     rsp_data_ff[24:19] != 6'd0 && rsp_data_ff[30:25] != 6'd0)
endmodule
`default_nettype wire
